// ===== rtl/stick_dead_zone_conditioner_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stick dead zone conditioner
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STICK_DEAD_ZONE_CONDITIONER_UNIT_ASSERT_SVH
`define STICK_DEAD_ZONE_CONDITIONER_UNIT_ASSERT_SVH

// Same-cycle implication
`define SDZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sdz_pkg.sv =====
// ----------------------------------------------------------------------------
// sdz_pkg
// Codes and constants shared by the dead zone conditioner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdz_pkg;

  // Dead zone register width (unsigned Q0.15)
  localparam int DZ_W = 15;

  // Mode codes of the input word
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_RADIAL = 2'd1;
  localparam logic [1:0] MODE_AXIAL  = 2'd2;

  // Configuration register indexes
  localparam logic REG_DEAD_ZONE    = 1'b0;
  localparam logic REG_STICK_SELECT = 1'b1;

  // Resolved handling of one word
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_AXIAL,
    KIND_RADIAL
  } kind_e;

endpackage

// ===== rtl/sdz_front.sv =====
// ----------------------------------------------------------------------------
// sdz_front
// Mode decode, axial result, squared length and low-length kill flag.
// Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdz_front import sdz_pkg::*; #(
  parameter int N   = 16,
  parameter int EXT = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [N-1:0]             axis_i,
  input  logic [N-1:0]             linked_i,
  input  logic [1:0]               mode_i,
  input  logic [N-2:0]             dz_i,
  input  logic [2*N-3:0]           dzsq_i,
  input  logic                     stick_i,
  output logic                     valid_o,
  output logic [2*N+2*EXT-1:0]     v_o,
  output logic [2*N+2:0]           side_o
);

  localparam int SQW = 2 * N + 2 * EXT;

  kind_e          kind;
  logic [N-1:0]   ax_d, ay_d, simple_d;

  logic           a_valid_q, b_valid_q, c_valid_q;
  logic [N-1:0]   a_ax_q, a_ay_q, a_simple_q, b_ax_q, b_simple_q, c_ax_q, c_simple_q;
  logic           a_neg_q, a_rad_q, b_neg_q, b_rad_q, c_neg_q, c_rad_q, c_kill_q;
  logic [2*N-1:0] b_sqx_q, b_sqy_q, len2, c_len2_q;

  // Resolve mode; code three acts as radial
  always_comb begin
    unique case (mode_i)
      MODE_NONE:  kind = KIND_PASS;
      MODE_AXIAL: kind = KIND_AXIAL;
      default:    kind = stick_i ? KIND_RADIAL : KIND_AXIAL;
    endcase
  end

  // Magnitudes and the non-radial result
  always_comb begin
    ax_d = axis_i[N-1] ? (~axis_i + N'(1)) : axis_i;
    ay_d = linked_i[N-1] ? (~linked_i + N'(1)) : linked_i;
    if (kind == KIND_AXIAL && ax_d < {1'b0, dz_i}) begin
      simple_d = '0;
    end else begin
      simple_d = axis_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  assign len2 = b_sqx_q + b_sqy_q;

  // Payload: decode, square, sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ax_q     <= ax_d;
      a_ay_q     <= ay_d;
      a_neg_q    <= axis_i[N-1];
      a_rad_q    <= (kind == KIND_RADIAL);
      a_simple_q <= simple_d;

      b_sqx_q    <= a_ax_q * a_ax_q;
      b_sqy_q    <= a_ay_q * a_ay_q;
      b_ax_q     <= a_ax_q;
      b_neg_q    <= a_neg_q;
      b_rad_q    <= a_rad_q;
      b_simple_q <= a_simple_q;

      c_len2_q   <= len2;
      c_kill_q   <= (len2 < {2'b00, dzsq_i}) || (len2 == '0);
      c_ax_q     <= b_ax_q;
      c_neg_q    <= b_neg_q;
      c_rad_q    <= b_rad_q;
      c_simple_q <= b_simple_q;
    end
  end

  assign valid_o = c_valid_q;
  assign v_o     = SQW'(c_len2_q) << (2 * EXT);
  assign side_o  = {c_kill_q, c_rad_q, c_neg_q, c_ax_q, c_simple_q};

endmodule

// ===== rtl/sdz_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// sdz_sqrt_stage
// One root bit of a restoring square root, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdz_sqrt_stage #(
  parameter int SQW    = 48,
  parameter int RW     = 24,
  parameter int SIDE_W = 35
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQW-1:0]    v_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SQW-1:0]    v_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RW+3:0] rem_c, trial, rem_n;
  logic          fit;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem_c = {rem_i, v_i[SQW-1 -: 2]};
    trial = (RW+4)'({root_i, 2'b01});
    fit   = rem_c >= trial;
    rem_n = fit ? (rem_c - trial) : rem_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o    <= v_i << 2;
      rem_o  <= rem_n[RW+1:0];
      root_o <= {root_i[RW-2:0], fit};
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/sdz_div_stage.sv =====
// ----------------------------------------------------------------------------
// sdz_div_stage
// One quotient bit of a restoring divider, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdz_div_stage #(
  parameter int DW     = 40,
  parameter int QW     = 16,
  parameter int SIDE_W = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW:0]       rem_i,
  input  logic [DW-1:0]     den_i,
  input  logic [QW-1:0]     quo_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DW:0]       rem_o,
  output logic [DW-1:0]     den_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic        fit;
  logic [DW:0] rem_n;

  // Compare, subtract, then shift for the next bit
  always_comb begin
    fit   = rem_i >= {1'b0, den_i};
    rem_n = fit ? (rem_i - {1'b0, den_i}) : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= {rem_n[DW-1:0], 1'b0};
      den_o  <= den_i;
      quo_o  <= {quo_i[QW-2:0], fit};
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/stick_dead_zone_conditioner_unit.sv =====
// Throughput: one word per cycle unless a stall holds the pipeline; the root takes
// one bit per stage and the divider one quotient bit per stage, so a new word can
// enter while earlier words are still in flight.
// A stalled output holds the pipeline only when its last stage is occupied.
// Reset clears all valid bits and both configuration registers to zero.
// ----------------------------------------------------------------------------
// stick_dead_zone_conditioner_unit
// Pass-through, axial and scaled radial dead zone for one stick axis sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_dead_zone_conditioner_unit import sdz_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] axis_value_i,
  input  logic [SAMPLE_BITS-1:0] linked_value_i,
  input  logic [1:0]             mode_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] conditioned_value_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [DZ_W-1:0]        cfg_data_i
);

  localparam int N       = SAMPLE_BITS;
  localparam int FRAC    = N - 1;
  localparam int EXT     = (32 - N) / 2;
  localparam int SQW     = 2 * N + 2 * EXT;
  localparam int RW      = N + EXT;
  localparam int DW      = N + RW;
  localparam int SIDE_W  = 2 * N + 3;
  localparam int DSIDE_W = N + 4;
  // Side word fields
  localparam int S_NEG   = 2 * N;
  localparam int S_RAD   = 2 * N + 1;
  localparam int S_KILL  = 2 * N + 2;

  // Configuration
  logic [DZ_W-1:0]      dz_q;
  logic                 stick_q;
  logic [FRAC+DZ_W-1:0] dz_wide;
  logic [FRAC-1:0]      dz_al;
  logic [2*FRAC-1:0]    dzsq_q;

  // Flow control
  logic en, out_free, last_valid;

  // Square root chain
  logic              sq_valid [0:RW];
  logic [SQW-1:0]    sq_v     [0:RW];
  logic [RW+1:0]     sq_rem   [0:RW];
  logic [RW-1:0]     sq_root  [0:RW];
  logic [SIDE_W-1:0] sq_side  [0:RW];

  // Scale stages
  logic              d_valid_q, e_valid_q, f_valid_q, g_valid_q;
  logic [RW-1:0]     d2, d_len_q, d_diff_q, e_len_q;
  logic [SIDE_W-1:0] d_side_q, e_side_q, f_side_q;
  logic              d_kill;
  logic [DW-1:0]     e_num_q, f_num_q, f_den_q, g_num_q, g_den_q;
  logic [N-1:0]      odz;
  logic [DSIDE_W-1:0] g_side_q;

  // Divider chain
  logic               dv_valid [0:N];
  logic [DW:0]        dv_rem   [0:N];
  logic [DW-1:0]      dv_den   [0:N];
  logic [N-1:0]       dv_quo   [0:N];
  logic [DSIDE_W-1:0] dv_side  [0:N];

  // Output
  logic [N-1:0] res, q, simple_v;
  logic         r_kill, r_rad, r_neg, r_ovf;
  logic         out_valid_q;
  logic [N-1:0] out_value_q;

  // Register writes; the port never refuses a word
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= '0;
      stick_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEAD_ZONE:    dz_q    <= cfg_data_i;
        REG_STICK_SELECT: stick_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Align the dead zone to the sample fraction
  assign dz_wide = {dz_q, {FRAC{1'b0}}};
  assign dz_al   = dz_wide[FRAC+DZ_W-1:DZ_W];

  always_ff @(posedge clk_i) begin
    dzsq_q <= dz_al * dz_al;
  end

  // Advance unless a result waits and the last stage is full
  assign out_free   = !out_valid_q || !out_stall_i;
  assign en         = out_free || !last_valid;
  assign in_stall_o = !en;

  sdz_front #(.N(N), .EXT(EXT)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .axis_i   (axis_value_i),
    .linked_i (linked_value_i),
    .mode_i   (mode_i),
    .dz_i     (dz_al),
    .dzsq_i   (dzsq_q),
    .stick_i  (stick_q),
    .valid_o  (sq_valid[0]),
    .v_o      (sq_v[0]),
    .side_o   (sq_side[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // Root of the scaled squared length
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    sdz_sqrt_stage #(.SQW(SQW), .RW(RW), .SIDE_W(SIDE_W)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .v_i     (sq_v[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_valid[i+1]),
      .v_o     (sq_v[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  assign d2  = RW'(dz_al) << EXT;
  assign odz = (N'(1) << FRAC) - N'(dz_al);

  // Drop to zero at or inside the dead zone, or with no axis component
  assign d_kill = sq_side[RW][S_KILL] || (sq_root[RW] <= d2)
                  || (sq_side[RW][2*N-1:N] == '0);

  // Scale stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= sq_valid[RW];
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
    end
  end

  // Length minus dead zone, numerator, denominator, overflow check
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_len_q  <= sq_root[RW];
      d_diff_q <= sq_root[RW] - d2;
      d_side_q <= {d_kill, sq_side[RW][S_KILL-1:0]};

      e_num_q  <= DW'(d_side_q[2*N-1:N]) * DW'(d_diff_q);
      e_len_q  <= d_len_q;
      e_side_q <= d_side_q;

      f_den_q  <= DW'(odz) * DW'(e_len_q);
      f_num_q  <= e_num_q;
      f_side_q <= e_side_q;

      g_num_q  <= f_num_q;
      g_den_q  <= f_den_q;
      g_side_q <= {f_side_q[S_KILL], f_side_q[S_RAD], f_side_q[S_NEG],
                   ({1'b0, f_num_q} >= {f_den_q, 1'b0}), f_side_q[N-1:0]};
    end
  end

  assign dv_valid[0] = g_valid_q;
  assign dv_rem[0]   = {1'b0, g_num_q};
  assign dv_den[0]   = g_den_q;
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = g_side_q;

  // Quotient, most significant bit first
  for (genvar k = 0; k < N; k++) begin : g_div
    sdz_div_stage #(.DW(DW), .QW(N), .SIDE_W(DSIDE_W)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .rem_i   (dv_rem[k]),
      .den_i   (dv_den[k]),
      .quo_i   (dv_quo[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .rem_o   (dv_rem[k+1]),
      .den_o   (dv_den[k+1]),
      .quo_o   (dv_quo[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  assign last_valid = dv_valid[N];

  // Pick the non-radial or zero result, else sign and saturate
  always_comb begin
    q        = dv_quo[N];
    simple_v = dv_side[N][N-1:0];
    r_ovf    = dv_side[N][N];
    r_neg    = dv_side[N][N+1];
    r_rad    = dv_side[N][N+2];
    r_kill   = dv_side[N][N+3];
    if (!r_rad) begin
      res = simple_v;
    end else if (r_kill) begin
      res = '0;
    end else if (r_neg) begin
      res = (r_ovf || q[N-1]) ? (N'(1) << FRAC) : (~q + N'(1));
    end else begin
      res = (r_ovf || q[N-1] || (&q[N-2:0])) ? ((N'(1) << FRAC) - N'(1)) : q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_value_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign conditioned_value_o = out_value_q;

endmodule

// ===== rtl/sdz_checker.sv =====
// ----------------------------------------------------------------------------
// sdz_checker
// Port-level checks of the conditioner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stick_dead_zone_conditioner_unit_assert.svh"

module sdz_checker import sdz_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [SAMPLE_BITS-1:0] axis_value_i,
  input logic [SAMPLE_BITS-1:0] linked_value_i,
  input logic [1:0]             mode_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] conditioned_value_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic                   cfg_index_i,
  input logic [DZ_W-1:0]        cfg_data_i
);

  // A stalled result word stays and holds its value
  `SDZ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(conditioned_value_o), "stalled result changed")

  // Input is held back only behind a waiting result
  `SDZ_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a waiting result")

  // Register writes are never refused
  `SDZ_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o, "register write refused")

endmodule

bind stick_dead_zone_conditioner_unit sdz_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdz_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick dead zone conditioner testbench
// Drives axis words with random gaps and output stalls, predicts each
// conditioned sample in a scoreboard and compares results in order.
// ----------------------------------------------------------------------------

class dead_zone_scoreboard;
  bit [14:0] dead_zone;
  bit        stick_select;
  bit [15:0] sample_q[$];
  int        errors;

  // Integer square root, floor
  function bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Conditioned sample for one word
  function bit [15:0] condition(bit signed [15:0] x, bit signed [15:0] y, bit [1:0] m);
    bit [63:0]  ax, ay, dz, len2, len, dz2, num, den, q;
    bit [127:0] q_wide;
    ax = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    ay = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    dz = dead_zone;
    if (m == sdz_pkg::MODE_NONE) return x;
    if (m == sdz_pkg::MODE_AXIAL || !stick_select) return (ax >= dz) ? x : 16'd0;
    len2 = ax * ax + ay * ay;
    if (len2 < dz * dz || len2 == 0) return 16'd0;
    len = floor_sqrt(len2 << 16);
    dz2 = dz << 8;
    if (len <= dz2 || ax == 0) return 16'd0;
    num = ax * (len - dz2);
    den = (64'd32768 - dz) * len;
    if (den == 0) return 16'd0;
    q_wide = (128'(num) << 15) / 128'(den);
    q = (q_wide >= (128'd1 << 64)) ? 64'd32768 : q_wide[63:0];
    if (x < 0) return (q >= 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q >= 32767) ? 16'h7fff : q[15:0];
  endfunction

  // Note an accepted input word
  function void note_word(bit [15:0] x, bit [15:0] y, bit [1:0] m);
    sample_q.push_back(condition(x, y, m));
  endfunction

  // Check one result word against the oldest expectation
  function void check_word(bit [15:0] got);
    bit [15:0] want;
    if (sample_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = sample_q.pop_front();
    if (want !== got) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module testbench;
  import sdz_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [15:0] axis_value_i = 0;
  logic [15:0] linked_value_i = 0;
  logic [1:0]  mode_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [15:0] conditioned_value_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 0;
  logic [14:0] cfg_data_i = 0;

  dead_zone_scoreboard sb = new();
  bit in_taken, cfg_taken, hold_req;

  stick_dead_zone_conditioner_unit dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watch handshakes at the rising edge
  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    cfg_taken = cfg_valid_i && cfg_ready_o;
    if (in_taken) sb.note_word(axis_value_i, linked_value_i, mode_i);
    if (out_valid_o && !out_stall_i) sb.check_word(conditioned_value_o);
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls; one long hold-off when requested
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
        out_stall_i <= 0;
      end else begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i <= 1;
          repeat (n) @(negedge clk_i);
        end
        out_stall_i <= 0;
      end
    end
  end

  task send_word(bit [15:0] x, bit [15:0] y, bit [1:0] m, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n != 0) begin
      in_valid_i <= 0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1;
    axis_value_i <= x;
    linked_value_i <= y;
    mode_i <= m;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // Drain, then write one register while idle
  task write_reg(logic idx, bit [14:0] data);
    in_valid_i <= 0;
    @(negedge clk_i);
    while (sb.sample_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 0;
    if (idx == REG_DEAD_ZONE) sb.dead_zone = data;
    else sb.stick_select = data[0];
  endtask

  function bit [15:0] rand_sample(bit [14:0] dz);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 16'($urandom_range(0, 2 * dz + 2) - dz - 1);
    if (r == 1) return 16'($urandom_range(0, 64) - 32);
    return 16'($urandom);
  endfunction

  bit [14:0] dz_set[8] = '{6554, 0, 32767, 16384, 3277, 32767, 1000, 0};
  bit        sel_set[8] = '{1, 1, 1, 1, 1, 0, 0, 0};

  initial begin
    bit [15:0] x, y;
    rst_ni = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_DEAD_ZONE, dz_set[p]);
      write_reg(REG_STICK_SELECT, sel_set[p]);
      if (p == 0) begin
        // Extremes, modes and boundary cases around a dead zone of 6554
        send_word(16'h7fff, 16'h7fff, MODE_RADIAL, 0);
        send_word(16'h8000, 16'h8000, MODE_RADIAL, 0);
        send_word(16'h0000, 16'h0000, MODE_RADIAL, 0);
        send_word(16'h0000, 16'h0000, MODE_NONE, 0);
        send_word(16'h8000, 16'h7fff, MODE_NONE, 0);
        send_word(16'd6554, 16'd0, MODE_AXIAL, 0);
        send_word(16'd6553, 16'd0, MODE_AXIAL, 0);
        send_word(-16'sd6554, 16'd0, MODE_AXIAL, 0);
        send_word(16'd6554, 16'd0, MODE_RADIAL, 0);
        send_word(16'd6553, 16'd0, MODE_RADIAL, 0);
        send_word(16'd0, 16'd20000, MODE_RADIAL, 0);
        send_word(16'd100, -16'sd20000, 2'd3, 0);
        send_word(16'h8000, 16'd5, 2'd3, 0);
        send_word(16'h8000, 16'd0, MODE_RADIAL, 0);
        send_word(16'h7fff, 16'd0, MODE_RADIAL, 0);
        send_word(16'h7fff, 16'h8000, MODE_AXIAL, 0);
      end
      if (p == 3) hold_req = 1;
      for (int i = 0; i < 230; i++) begin
        x = rand_sample(dz_set[p]);
        y = rand_sample(dz_set[p]);
        send_word(x, y, 2'($urandom_range(0, 3)), i % 100 >= 30);
      end
    end
    in_valid_i <= 0;
    while (sb.sample_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("** stick_dead_zone_conditioner_unit: PASSED **");
    end else begin
      $display("** stick_dead_zone_conditioner_unit: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("** stick_dead_zone_conditioner_unit: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sdz_pkg.sv
rtl/sdz_front.sv
rtl/sdz_sqrt_stage.sv
rtl/sdz_div_stage.sv
rtl/stick_dead_zone_conditioner_unit.sv
rtl/sdz_checker.sv
test/testbench.sv
